// ----- rtl/core/fcrs_pkg.sv -----
// Shared types and constants for the favorite channel ring stepper.
package fcrs_pkg;

  localparam int MAX_SLOTS     = 8;
  localparam int SLOTS_DEFAULT = 8;
  localparam int CH_W          = 8;
  localparam int COUNT_W       = 4;
  localparam int CFG_W         = 64;
  localparam int REG_IDX_W     = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SLOT_CHANNELS = 2'd0,
    REG_SLOT_COUNT    = 2'd1,
    REG_CHANNEL_MAX   = 2'd2,
    REG_ENABLE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]   slot_channels;
    logic [COUNT_W-1:0] slot_count;
    logic [CH_W-1:0]    channel_max;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic [MAX_SLOTS-1:0] uniq;
    logic [MAX_SLOTS-1:0] dup;
    logic [COUNT_W-1:0]   size;
  } ring_t;

endpackage

// ----- rtl/core/fcrs_cfg_regs.sv -----
// Configuration register file for the favorite channel ring stepper.
module fcrs_cfg_regs import fcrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_SLOT_CHANNELS: begin
          cfg.slot_channels <= wr_data;
        end
        REG_SLOT_COUNT: begin
          cfg.slot_count <= wr_data[COUNT_W-1:0];
        end
        REG_CHANNEL_MAX: begin
          cfg.channel_max <= wr_data[CH_W-1:0];
        end
        REG_ENABLE: begin
          cfg.enable <= wr_data[0];
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/fcrs_ring.sv -----
// Usable-slot qualification, first-occurrence dedup and ring size.
module fcrs_ring import fcrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  cfg_t  cfg,
  output ring_t ring
);

  logic [MAX_SLOTS-1:0] usable;
  logic [CH_W-1:0]      ch [MAX_SLOTS];

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      ch[i]     = cfg.slot_channels[i*CH_W +: CH_W];
      usable[i] = (i < SLOTS) && (COUNT_W'(i) < cfg.slot_count) &&
                  (ch[i] != '0) && (ch[i] <= cfg.channel_max);
    end
  end

  always_comb begin
    logic seen;
    logic [COUNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      seen = 1'b0;
      // any earlier usable slot with the same channel makes this one a repeat
      for (int j = 0; j < i; j++) begin
        seen = seen | (usable[j] && (ch[j] == ch[i]));
      end
      ring.dup[i]  = usable[i] && seen;
      ring.uniq[i] = usable[i] && !seen;
      cnt = cnt + COUNT_W'(ring.uniq[i]);
    end
    ring.size = cnt;
  end

endmodule

// ----- rtl/core/fcrs_step.sv -----
// Neighbor selection in the ring, with wrap and entry for unknown channels.
module fcrs_step import fcrs_pkg::*; (
  input  logic [CFG_W-1:0]     slot_channels,
  input  logic [MAX_SLOTS-1:0] uniq,
  input  logic [CH_W-1:0]      current_channel,
  input  logic                 dir_up,
  output logic [CH_W-1:0]      next_channel
);

  function automatic logic [MAX_SLOTS-1:0] lowest(input logic [MAX_SLOTS-1:0] m);
    return m & (~m + MAX_SLOTS'(1));
  endfunction

  function automatic logic [MAX_SLOTS-1:0] highest(input logic [MAX_SLOTS-1:0] m);
    logic [MAX_SLOTS-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (m[i]) begin
        r = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  logic [MAX_SLOTS-1:0] match;
  logic [MAX_SLOTS-1:0] after;
  logic [MAX_SLOTS-1:0] prior;
  logic [MAX_SLOTS-1:0] pick;

  always_comb begin
    logic hit;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match[i] = uniq[i] && (slot_channels[i*CH_W +: CH_W] == current_channel);
    end
    hit = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      after[i] = uniq[i] && hit;
      hit      = hit | match[i];
    end
    hit = 1'b0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      prior[i] = uniq[i] && hit;
      hit      = hit | match[i];
    end
  end

  // no neighbor on that side: wrap, which is also the entry point for a miss
  always_comb begin
    if (dir_up) begin
      pick = (after != '0) ? lowest(after) : lowest(uniq);
    end else begin
      pick = (prior != '0) ? highest(prior) : highest(uniq);
    end
  end

  always_comb begin
    logic [CH_W-1:0] sel;
    sel = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      sel = sel | ({CH_W{pick[i]}} & slot_channels[i*CH_W +: CH_W]);
    end
    next_channel = (uniq == '0) ? current_channel : sel;
  end

endmodule

// ----- rtl/core/favorite_channel_ring_step_core.sv -----
// Top level of the favorite channel ring stepper.
//
// Takes one word (current channel, direction) per cycle and presents one result word
// at the output after acceptance, by way of an input register, one pass through the
// slot compare and selection network, and an output register. The ring is rebuilt from
// the configuration registers every cycle, so there is no kept state and no fill
// or clearing time. Sustained rate is one word per cycle; the input stalls only
// while its register holds a word and the output register is full and stalled.
module favorite_channel_ring_step_core import fcrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CH_W-1:0]      current_channel,
  input  logic                 dir_up,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      next_channel,
  output logic [COUNT_W-1:0]   ring_size,
  output logic                 active,
  output logic [MAX_SLOTS-1:0] duplicate_mask
);

  cfg_t  cfg;
  ring_t ring;

  logic            s1_valid;
  logic [CH_W-1:0] s1_channel;
  logic            s1_dir_up;
  logic [CH_W-1:0] step_channel;
  logic            out_advance;

  fcrs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fcrs_ring #(.SLOTS(SLOTS)) u_ring (
    .cfg  (cfg),
    .ring (ring)
  );

  fcrs_step u_step (
    .slot_channels   (cfg.slot_channels),
    .uniq            (ring.uniq),
    .current_channel (s1_channel),
    .dir_up          (s1_dir_up),
    .next_channel    (step_channel)
  );

  assign out_advance = !out_valid || !out_stall;
  assign in_stall    = s1_valid && !out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // hold the input word until the result register can take it, and load the result register when it advances
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_channel <= current_channel;
      s1_dir_up  <= dir_up;
    end
    if (out_advance && s1_valid) begin
      next_channel   <= step_channel;
      ring_size      <= ring.size;
      active         <= cfg.enable && (ring.size != '0);
      duplicate_mask <= ring.dup;
    end
  end

  a_active_needs_ring: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!active || ring_size != '0))
    else $error("active set with an empty ring");

  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((duplicate_mask >> SLOTS) == '0))
    else $error("duplicate bit set beyond the slot range");

  a_slot_budget: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(duplicate_mask) + int'(ring_size) <= SLOTS))
    else $error("ring size plus duplicates exceeds slot count");

  a_word_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_advance) |=> out_valid)
    else $error("word lost between input and result register");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_advance) |=> (s1_valid && $stable(s1_channel)))
    else $error("stalled input register changed");

endmodule
